// ===== hdl/buvc_pkg.sv =====
// Shared constants, types and codes for the undervoltage cutoff and duty compensation block.
`default_nettype none

package buvc_pkg;

   // Field widths.
   localparam int VOLT_BITS = 16;
   localparam int DUTY_BITS = 16;
   localparam int CNT_BITS  = 16;

   // Derived arithmetic widths.
   localparam int PROD_W    = VOLT_BITS + DUTY_BITS;
   localparam int NUMER_W   = PROD_W + 2;
   localparam int REM_W     = VOLT_BITS + 1;
   localparam int DIV_CNT_W = $clog2(DUTY_BITS);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_FIELDS_W = VOLT_BITS + 1 + DUTY_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + DUTY_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int OP_W         = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // Register reset values.
   localparam logic [VOLT_BITS-1:0] RST_SAMPLE_MIN  = VOLT_BITS'(6000);
   localparam logic [VOLT_BITS-1:0] RST_SAMPLE_MAX  = VOLT_BITS'(13500);
   localparam logic [VOLT_BITS-1:0] RST_LOW_CUTOFF  = VOLT_BITS'(10500);
   localparam logic [VOLT_BITS-1:0] RST_RECOVER     = VOLT_BITS'(11100);
   localparam logic [CNT_BITS-1:0]  RST_CONFIRM     = CNT_BITS'(200);
   localparam logic [VOLT_BITS-1:0] RST_NOMINAL     = VOLT_BITS'(11100);
   localparam logic [DUTY_BITS-1:0] RST_MOTOR_LIMIT = DUTY_BITS'(8000);
   localparam logic [DUTY_BITS-1:0] RST_PWM_MAX     = DUTY_BITS'(10000);

   // Operation codes carried in the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_RECOVER = 2'd1,
      OP_DUTY    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_MIN  = 3'd0,
      CSR_SAMPLE_MAX  = 3'd1,
      CSR_LOW_CUTOFF  = 3'd2,
      CSR_RECOVER     = 3'd3,
      CSR_CONFIRM     = 3'd4,
      CSR_NOMINAL     = 3'd5,
      CSR_MOTOR_LIMIT = 3'd6,
      CSR_PWM_MAX     = 3'd7
   } csr_idx_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_L,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   // Commands to the shared arithmetic unit.
   typedef enum logic [2:0] {
      DP_HOLD,
      DP_LOAD,
      DP_MUL_P,
      DP_MUL_L,
      DP_CMP,
      DP_DIV
   } dp_cmd_type;

   // Sequencer status towards the top level.
   typedef struct packed {
      logic ready;
      logic load_rsp;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== hdl/buvc_datapath.sv =====
// Shared multiplier and subtractor with the operand and quotient registers of the duty unit.
`default_nettype none

module buvc_datapath
   import buvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire dp_cmd_type           cmd,
   input  wire logic [DUTY_BITS-1:0] duty_base,
   input  wire logic [VOLT_BITS-1:0] voltage_mv,
   input  wire logic [VOLT_BITS-1:0] nominal_mv,
   input  wire logic [DUTY_BITS-1:0] duty_lim,
   output logic                      sat,
   output logic [DUTY_BITS-1:0]      duty
);

   logic [DUTY_BITS-1:0] base_ff, base_in;
   logic [VOLT_BITS-1:0] volt_ff, volt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    lmul_ff, lmul_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DUTY_BITS-1:0] quot_ff, quot_in;
   logic                 sat_ff, sat_in;

   logic [DUTY_BITS-1:0] mul_a;
   logic [VOLT_BITS-1:0] mul_b;
   logic [PROD_W-1:0]    mul_p;
   logic [NUMER_W-1:0]   numer;
   logic [REM_W:0]       rem_sh;
   logic [PROD_W-1:0]    sub_a;
   logic [PROD_W-1:0]    sub_b;
   logic [PROD_W:0]      diff;
   logic                 borrow;

   // Shared multiplier: base times nominal, then limit times voltage.
   assign mul_a = (cmd == DP_MUL_P) ? base_ff : duty_lim;
   assign mul_b = (cmd == DP_MUL_P) ? nominal_mv : volt_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Rounding numerator 2P + v for the half-up quotient.
   assign numer  = {1'b0, prod_ff, 1'b0} + NUMER_W'(volt_ff);
   assign rem_sh = {rem_ff, quot_ff[DUTY_BITS-1]};

   // Shared subtractor: saturation compare, then one restoring divide step per cycle.
   always_comb begin
      if (cmd == DP_DIV) begin
         sub_a = PROD_W'(rem_sh);
         sub_b = PROD_W'({volt_ff, 1'b0});
      end else begin
         sub_a = lmul_ff;
         sub_b = prod_ff;
      end
   end

   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = diff[PROD_W];
   assign sat    = borrow;

   // Next values of the working registers.
   always_comb begin
      base_in = base_ff;
      volt_in = volt_ff;
      prod_in = prod_ff;
      lmul_in = lmul_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      unique case (cmd)
         DP_LOAD: begin
            base_in = duty_base;
            // A zero reading divides as one millivolt.
            volt_in = (voltage_mv == '0) ? VOLT_BITS'(1) : voltage_mv;
         end
         DP_MUL_P: begin
            prod_in = mul_p;
         end
         DP_MUL_L: begin
            lmul_in = mul_p;
         end
         DP_CMP: begin
            sat_in  = borrow;
            rem_in  = numer[DUTY_BITS +: REM_W];
            quot_in = numer[DUTY_BITS-1:0];
         end
         DP_DIV: begin
            rem_in  = borrow ? rem_sh[REM_W-1:0] : diff[REM_W-1:0];
            quot_in = {quot_ff[DUTY_BITS-2:0], ~borrow};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      volt_ff <= volt_in;
      prod_ff <= prod_in;
      lmul_ff <= lmul_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign duty = sat_ff ? duty_lim : quot_ff;

endmodule

`default_nettype wire

// ===== hdl/buvc_ctrl.sv =====
// Sequencer that steps the shared arithmetic unit through one duty calculation.
`default_nettype none

module buvc_ctrl
   import buvc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   input  wire logic      calc_start,
   input  wire logic      sat,
   input  wire logic      rsp_free,
   output ctrl_status_type status,
   output dp_cmd_type      cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   accept;
   logic                   div_last;

   assign accept   = req_tvalid && (state_ff == ST_IDLE);
   assign div_last = (cnt_ff == DIV_CNT_W'(DUTY_BITS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = calc_start ? ST_MUL_P : ST_DONE;
            end
         end
         ST_MUL_P: state_in = ST_MUL_L;
         ST_MUL_L: state_in = ST_CMP;
         ST_CMP: begin
            state_in = sat ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      status.ready    = 1'b0;
      status.load_rsp = 1'b0;
      cmd             = DP_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            status.ready = 1'b1;
            if (accept) begin
               cmd = DP_LOAD;
            end
         end
         ST_MUL_P: cmd = DP_MUL_P;
         ST_MUL_L: cmd = DP_MUL_L;
         ST_CMP:   cmd = DP_CMP;
         ST_DIV:   cmd = DP_DIV;
         ST_DONE:  status.load_rsp = rsp_free;
         default: begin
         end
      endcase
   end

   // Divide step counter.
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_CMP) begin
         cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/battery_undervoltage_cutoff_duty_comp.sv =====
// Top level of the battery undervoltage cutoff with duty voltage compensation.
// Each request transaction carries one operation (tick, recovery check or duty request) with a
// pack voltage sample. Ticks and recovery checks are decided in the cycle of acceptance; the
// done state then loads their response once the output register is free. A duty request with a
// valid sample and no cutoff latched runs on one shared 16 x 16 multiplier and one subtractor
// under a small sequencer: base times nominal, limit times voltage, a saturation compare and,
// unless the result saturates, one restoring divide step per duty bit (16). The block takes one
// request at a time; req_tready is low from acceptance until the response has been loaded into
// the output register, which then holds it until rsp_tready. Configuration writes are always
// ready and must only be issued while no transaction is outstanding.
`default_nettype none

module battery_undervoltage_cutoff_duty_comp
   import buvc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // voltage_mv, motors_on, duty_base, pad
   input  wire logic [OP_W-1:0]       req_tuser,  // op
   // Response stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // trip, motor_allowed, duty, pad
   // Configuration write channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [VOLT_BITS-1:0] sample_min_ff, sample_max_ff, low_cutoff_ff, recover_ff, nominal_ff;
   logic [CNT_BITS-1:0]  confirm_ff;
   logic [DUTY_BITS-1:0] motor_limit_ff, pwm_max_ff;

   // Monitor state.
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 latched_ff, latched_in;

   // Pending response fields.
   logic                 pend_trip_ff, pend_trip_in;
   logic                 pend_calc_ff, pend_calc_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_trip_ff, rsp_allowed_ff;
   logic [DUTY_BITS-1:0] rsp_duty_ff;

   // Unpacked request fields.
   op_type               req_op;
   logic [VOLT_BITS-1:0] req_voltage_mv;
   logic                 req_motors_on;
   logic [DUTY_BITS-1:0] req_duty_base;

   ctrl_status_type      status;
   dp_cmd_type           dp_cmd;
   logic                 accept;
   logic                 sample_ok;
   logic                 calc_start;
   logic                 rsp_free;
   logic                 sat;
   logic [DUTY_BITS-1:0] duty_lim;
   logic [DUTY_BITS-1:0] dp_duty;
   logic [CNT_BITS-1:0]  count_inc;

   assign req_op         = op_type'(req_tuser);
   assign req_voltage_mv = req_tdata[VOLT_BITS-1:0];
   assign req_motors_on  = req_tdata[VOLT_BITS];
   assign req_duty_base  = req_tdata[VOLT_BITS+1 +: DUTY_BITS];

   assign req_tready = status.ready;
   assign accept     = req_tvalid && status.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Sample validity and the effective duty limit.
   assign sample_ok  = (req_voltage_mv >= sample_min_ff) && (req_voltage_mv <= sample_max_ff);
   assign duty_lim   = (motor_limit_ff < pwm_max_ff) ? motor_limit_ff : pwm_max_ff;
   assign calc_start = (req_op == OP_DUTY) && sample_ok && !latched_ff;
   assign count_inc  = (count_ff < confirm_ff) ? count_ff + CNT_BITS'(1) : count_ff;

   // Tick and recovery updates, decided at acceptance.
   always_comb begin
      count_in     = count_ff;
      latched_in   = latched_ff;
      pend_trip_in = pend_trip_ff;
      pend_calc_in = pend_calc_ff;
      if (accept) begin
         pend_trip_in = 1'b0;
         pend_calc_in = calc_start;
         unique case (req_op)
            OP_TICK: begin
               if (!latched_ff) begin
                  if (!req_motors_on) begin
                     count_in = '0;
                  end else if (!sample_ok || (req_voltage_mv <= low_cutoff_ff)) begin
                     count_in = count_inc;
                     if (count_inc >= confirm_ff) begin
                        latched_in   = 1'b1;
                        pend_trip_in = 1'b1;
                     end
                  end else begin
                     count_in = '0;
                  end
               end
            end
            OP_RECOVER: begin
               if (sample_ok && (req_voltage_mv >= recover_ff)) begin
                  count_in   = '0;
                  latched_in = 1'b0;
               end
            end
            OP_DUTY, OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         latched_ff   <= 1'b0;
         pend_trip_ff <= 1'b0;
         pend_calc_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         latched_ff   <= latched_in;
         pend_trip_ff <= pend_trip_in;
         pend_calc_ff <= pend_calc_in;
      end
   end

   // Configuration register writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_min_ff  <= RST_SAMPLE_MIN;
         sample_max_ff  <= RST_SAMPLE_MAX;
         low_cutoff_ff  <= RST_LOW_CUTOFF;
         recover_ff     <= RST_RECOVER;
         confirm_ff     <= RST_CONFIRM;
         nominal_ff     <= RST_NOMINAL;
         motor_limit_ff <= RST_MOTOR_LIMIT;
         pwm_max_ff     <= RST_PWM_MAX;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SAMPLE_MIN:  sample_min_ff  <= VOLT_BITS'(csr_data);
            CSR_SAMPLE_MAX:  sample_max_ff  <= VOLT_BITS'(csr_data);
            CSR_LOW_CUTOFF:  low_cutoff_ff  <= VOLT_BITS'(csr_data);
            CSR_RECOVER:     recover_ff     <= VOLT_BITS'(csr_data);
            CSR_CONFIRM:     confirm_ff     <= CNT_BITS'(csr_data);
            CSR_NOMINAL:     nominal_ff     <= VOLT_BITS'(csr_data);
            CSR_MOTOR_LIMIT: motor_limit_ff <= DUTY_BITS'(csr_data);
            CSR_PWM_MAX:     pwm_max_ff     <= DUTY_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Sequencer and shared arithmetic unit.
   buvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .calc_start (calc_start),
      .sat        (sat),
      .rsp_free   (rsp_free),
      .status     (status),
      .cmd        (dp_cmd)
   );

   buvc_datapath u_datapath (
      .clock      (clock),
      .cmd        (dp_cmd),
      .duty_base  (req_duty_base),
      .voltage_mv (req_voltage_mv),
      .nominal_mv (nominal_ff),
      .duty_lim   (duty_lim),
      .sat        (sat),
      .duty       (dp_duty)
   );

   // Response output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.load_rsp) begin
         rsp_trip_ff    <= pend_trip_ff;
         rsp_allowed_ff <= !latched_ff;
         rsp_duty_ff    <= pend_calc_ff ? dp_duty : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_duty_ff, rsp_allowed_ff, rsp_trip_ff});

   // A response that reports a trip never allows the motors.
   a_trip_blocks_motor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trip_ff |-> !rsp_allowed_ff)
      else $error("trip reported with motors still allowed");

   // A non-zero duty is only produced while the motors are allowed.
   a_duty_needs_allowed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_duty_ff != '0) |-> rsp_allowed_ff)
      else $error("non-zero duty issued while cutoff latched");

   // The block takes one request at a time.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while previous one still in progress");

endmodule

`default_nettype wire
